/* rtl/core/c8dfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8dfr_pkg
// Shared constants, types and helper functions of the CRC-8 packet deframer.
// ----------------------------------------------------------------------------
package c8dfr_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int OCC_W       = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W       = OCC_W + 1;
    localparam int FIT_LIMIT   = ((STORE_DEPTH - 4) < 60) ? (STORE_DEPTH - 4) : 60;

    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h8C;
    localparam logic [BYTE_W-1:0] CRC_INIT  = 8'h00;

    // Input kinds carried on the slave tuser bit.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    // Register indexes as decoded from paddr[2].
    localparam logic REG_START = 1'b0;
    localparam logic REG_STOP  = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] stop_marker;
    } t_cfg;

    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic              found;
        logic [LEN_W-1:0]  payload_length;
        logic [LEN_W-1:0]  byte_index;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
        logic              overflowed;
    } t_result;

    // Ring position plus offset; the sum always stays below twice the depth.
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                 input logic [OCC_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(off);
        if (s >= SUM_W'(STORE_DEPTH)) begin
            s = s - SUM_W'(STORE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    // Reflected CRC-8, one byte, least significant bit first.
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] d;
        c = crc;
        d = b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

/* rtl/core/c8dfr_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8dfr_store
// Ring byte store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module c8dfr_store (
    input  logic                      i_clk,
    input  c8dfr_pkg::t_mem_req       i_req,
    output logic [c8dfr_pkg::BYTE_W-1:0] o_rdata
);
    import c8dfr_pkg::*;

    logic [BYTE_W-1:0] r_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/c8dfr_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8dfr_seq
// Store pointers and the poll sequencer: scan, frame check, CRC walk, emit.
// ----------------------------------------------------------------------------
module c8dfr_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  c8dfr_pkg::t_cfg               i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [c8dfr_pkg::BYTE_W-1:0]  i_rx_byte,
    output c8dfr_pkg::t_mem_req           o_req,
    input  logic [c8dfr_pkg::BYTE_W-1:0]  i_rdata,
    input  logic                          i_out_free,
    output logic                          o_res_load,
    output c8dfr_pkg::t_result            o_res
);
    import c8dfr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_LEN_RD,
        ST_LEN_CHK,
        ST_STOP_RD,
        ST_STOP_CHK,
        ST_CRC_RD,
        ST_CRC_ACC,
        ST_CRC_CMP,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_NOT_FOUND
    } t_state;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic              r_ovf_flag, n_ovf_flag;
    logic              r_ovf_poll, n_ovf_poll;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic [BYTE_W-1:0] r_crc, n_crc;

    logic              drop_en;
    logic [OCC_W-1:0]  drop_cnt;
    logic [OCC_W-1:0]  len_ext;
    logic [OCC_W-1:0]  idx_ext;
    logic              emit_last;

    assign len_ext   = OCC_W'(r_len);
    assign idx_ext   = OCC_W'(r_idx);
    assign emit_last = (r_len == '0) || (r_idx == r_len - LEN_W'(1));
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_rp       = r_rp;
        n_occ      = r_occ;
        n_ovf_flag = r_ovf_flag;
        n_ovf_poll = r_ovf_poll;
        n_len      = r_len;
        n_idx      = r_idx;
        n_crc      = r_crc;
        drop_en    = 1'b0;
        drop_cnt   = OCC_W'(1);
        o_req      = '0;
        o_res_load = 1'b0;
        o_res      = '0;
        o_res.last       = 1'b1;
        o_res.overflowed = r_ovf_poll;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_PUSH) begin
                        if (r_occ == OCC_W'(STORE_DEPTH)) begin
                            n_ovf_flag = 1'b1;
                        end else begin
                            o_req.wr_en   = 1'b1;
                            o_req.wr_addr = ring_add(r_rp, r_occ);
                            o_req.wr_data = i_rx_byte;
                            n_occ         = r_occ + OCC_W'(1);
                        end
                    end else begin
                        n_ovf_poll = r_ovf_flag;
                        n_ovf_flag = 1'b0;
                        n_state    = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                if (r_occ == '0) begin
                    n_state = ST_NOT_FOUND;
                end else begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = r_rp;
                    n_state       = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (i_rdata == i_cfg.start_marker) begin
                    n_state = ST_LEN_RD;
                end else begin
                    drop_en = 1'b1;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_LEN_RD: begin
                if (r_occ <= OCC_W'(1)) begin
                    n_state = ST_NOT_FOUND;
                end else begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = ring_add(r_rp, OCC_W'(1));
                    n_state       = ST_LEN_CHK;
                end
            end
            ST_LEN_CHK: begin
                if (i_rdata > BYTE_W'(FIT_LIMIT)) begin
                    // A length that can never fit loses its start byte.
                    drop_en = 1'b1;
                    n_state = ST_NOT_FOUND;
                end else if ({1'b0, r_occ} < (SUM_W'(i_rdata) + SUM_W'(4))) begin
                    n_state = ST_NOT_FOUND;
                end else begin
                    n_len   = i_rdata[LEN_W-1:0];
                    n_state = ST_STOP_RD;
                end
            end
            ST_STOP_RD: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = ring_add(r_rp, len_ext + OCC_W'(2));
                n_state       = ST_STOP_CHK;
            end
            ST_STOP_CHK: begin
                if (i_rdata != i_cfg.stop_marker) begin
                    drop_en = 1'b1;
                    n_state = ST_NOT_FOUND;
                end else begin
                    n_idx   = '0;
                    n_crc   = CRC_INIT;
                    n_state = ST_CRC_RD;
                end
            end
            ST_CRC_RD: begin
                o_req.rd_en = 1'b1;
                if (r_idx == r_len) begin
                    o_req.rd_addr = ring_add(r_rp, len_ext + OCC_W'(3));
                    n_state       = ST_CRC_CMP;
                end else begin
                    o_req.rd_addr = ring_add(r_rp, idx_ext + OCC_W'(2));
                    n_state       = ST_CRC_ACC;
                end
            end
            ST_CRC_ACC: begin
                n_crc   = crc8_update(r_crc, i_rdata);
                n_idx   = r_idx + LEN_W'(1);
                n_state = ST_CRC_RD;
            end
            ST_CRC_CMP: begin
                if (i_rdata != r_crc) begin
                    drop_en = 1'b1;
                    n_state = ST_NOT_FOUND;
                end else begin
                    n_idx   = '0;
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = ring_add(r_rp, idx_ext + OCC_W'(2));
                n_state       = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                // The read data register holds while the output side stalls.
                if (i_out_free) begin
                    o_res_load           = 1'b1;
                    o_res.found          = 1'b1;
                    o_res.payload_length = r_len;
                    o_res.byte_index     = r_idx;
                    o_res.data_byte      = (r_len == '0) ? '0 : i_rdata;
                    o_res.last           = emit_last;
                    if (emit_last) begin
                        drop_en  = 1'b1;
                        drop_cnt = len_ext + OCC_W'(4);
                        n_state  = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + LEN_W'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            ST_NOT_FOUND: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (drop_en) begin
            n_rp  = ring_add(r_rp, drop_cnt);
            n_occ = r_occ - drop_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rp       <= '0;
            r_occ      <= '0;
            r_ovf_flag <= 1'b0;
            r_ovf_poll <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rp       <= n_rp;
            r_occ      <= n_occ;
            r_ovf_flag <= n_ovf_flag;
            r_ovf_poll <= n_ovf_poll;
        end
        r_len <= n_len;
        r_idx <= n_idx;
        r_crc <= n_crc;
    end

endmodule

/* rtl/core/crc8_packet_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_packet_deframer
// Ring-buffered link byte store with CRC-8 checked frame extraction on poll.
//
//   Channel   Dir  Signals                         Content
//   s         in   i_s_tvalid/o_s_tready           tuser: kind; tdata: rx_byte
//   m         out  o_m_tvalid/i_m_tready/tlast     tuser: found, overflowed;
//                                                  tdata: length, index, byte
//   apb       in   psel/penable/pwrite/paddr/...   start_marker, stop_marker
//
// A push is stored without leaving the idle state. A poll reads the store
// one byte at a time on the single read port: the leading bytes it scans,
// a frame's length, stop, payload and CRC, its payload again; stalls hold it.
// Reset is synchronous and active low; the store contents need no clearing.
// A finished result waits in the output register while new items are taken.
// ----------------------------------------------------------------------------
module crc8_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [5:0] payload_length, [11:6] byte_index,
                                     // [19:12] data_byte, [23:20] zero
    output logic [1:0]  o_m_tuser,   // [0] found, [1] overflowed
    output logic        o_m_tlast,   // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import c8dfr_pkg::*;

    t_cfg              r_cfg;
    t_mem_req          mem_req;
    logic [BYTE_W-1:0] mem_rdata;
    logic              out_free;
    logic              res_load;
    t_result           res;
    logic              r_m_valid;
    t_result           r_res;

    // Configuration registers.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STOP) ? 32'(r_cfg.stop_marker)
                                           : 32'(r_cfg.start_marker);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= 8'hFF;
            r_cfg.stop_marker  <= 8'h00;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_START) begin
                r_cfg.start_marker <= pwdata[BYTE_W-1:0];
            end else begin
                r_cfg.stop_marker <= pwdata[BYTE_W-1:0];
            end
        end
    end

    c8dfr_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    c8dfr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_kind     (i_s_tuser),
        .i_rx_byte  (i_s_tdata),
        .o_req      (mem_req),
        .i_rdata    (mem_rdata),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_res      (res)
    );

    // Output register.
    assign out_free = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (res_load) begin
            r_res <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'd0, r_res.data_byte, r_res.byte_index, r_res.payload_length};
    assign o_m_tuser  = {r_res.overflowed, r_res.found};
    assign o_m_tlast  = r_res.last;

endmodule

/* rtl/core/c8dfr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8dfr_checker
// Port-level checks of the deframer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module c8dfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // A not-found result is a single, all-zero closing item.
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tlast && (o_m_tdata == 24'd0))
        else $error("malformed not-found result");

    // Payload items stay inside the frame, and the last one closes it.
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] && (o_m_tdata[5:0] != 6'd0) |->
            (o_m_tdata[11:6] < o_m_tdata[5:0])
            && (o_m_tlast == (o_m_tdata[11:6] == (o_m_tdata[5:0] - 6'd1))))
        else $error("byte index out of frame");

    // An empty good frame gives one closing item with no data.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] && (o_m_tdata[5:0] == 6'd0) |->
            o_m_tlast && (o_m_tdata[19:6] == 14'd0))
        else $error("malformed empty frame result");

    // A push completes in its own cycle.
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser |=> o_s_tready)
        else $error("push left the block busy");

endmodule

bind crc8_packet_deframer c8dfr_checker u_c8dfr_checker (.*);

/* verif/tb_crc8_packet_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc8_packet_deframer
// Self-checking bench for the CRC-8 packet deframer. Bytes and polls go in
// on the input stream and the APB port sets the start and stop markers. A
// byte-level model of the ring store predicts every result of every poll.
// A short table of hand-picked items comes first. Random frames follow,
// clean or broken on purpose, under several marker settings. Both stream
// sides stall at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module tb_crc8_packet_deframer;
    import c8dfr_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int QUIET_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 6;

    typedef enum logic [1:0] {CHK_PREDICTED, CHK_NOT_FOUND, CHK_EMPTY_FRAME} t_check;
    typedef enum logic [2:0] {
        FLAW_NONE, FLAW_STOP, FLAW_CRC, FLAW_LENGTH, FLAW_SHORT
    } t_frame_flaw;
    typedef enum logic [1:0] {EXTRA_NONE, EXTRA_BACKPRESSURE, EXTRA_OVERFLOW} t_phase_extra;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        t_check     chk;
    } t_stim_row;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = KIND_PUSH;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'b000;
    logic [31:0] pwdata   = 32'h0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic [31:0] prdata;
    logic        pready;

    // Model of the ring store and the marker registers.
    logic [7:0]  ring [STORE_DEPTH];
    int unsigned ring_head     = 0;
    int unsigned ring_count    = 0;
    logic        overflow_seen = 1'b0;
    logic [7:0]  start_byte    = 8'hFF;
    logic [7:0]  stop_byte     = 8'h00;

    t_result     poll_results [$];
    t_result     results_due [$];
    t_result     due;
    t_result     seen;
    int unsigned items_sent   = 0;
    int          fail_count   = 0;
    bit          hold_req     = 1'b0;
    int unsigned idle_cycles  = 0;

    // Hand-picked items, run once under the reset markers (start FF, stop 00).
    t_stim_row directed [24] = '{
        '{KIND_POLL, 8'h00, CHK_NOT_FOUND},     // empty store
        '{KIND_PUSH, 8'hFF, CHK_PREDICTED},
        '{KIND_POLL, 8'h00, CHK_NOT_FOUND},     // start byte alone
        '{KIND_PUSH, 8'h3D, CHK_PREDICTED},     // length 61 can never fit
        '{KIND_POLL, 8'h00, CHK_NOT_FOUND},
        '{KIND_PUSH, 8'hFF, CHK_PREDICTED},
        '{KIND_PUSH, 8'h00, CHK_PREDICTED},
        '{KIND_PUSH, 8'h00, CHK_PREDICTED},
        '{KIND_PUSH, 8'h00, CHK_PREDICTED},
        '{KIND_POLL, 8'hA5, CHK_EMPTY_FRAME},   // skips 3D, then a good empty frame
        '{KIND_PUSH, 8'hFF, CHK_PREDICTED},
        '{KIND_PUSH, 8'h02, CHK_PREDICTED},
        '{KIND_PUSH, 8'hAA, CHK_PREDICTED},
        '{KIND_POLL, 8'h00, CHK_NOT_FOUND},     // frame not complete yet
        '{KIND_PUSH, 8'h55, CHK_PREDICTED},
        '{KIND_PUSH, 8'h01, CHK_PREDICTED},
        '{KIND_PUSH, 8'h00, CHK_PREDICTED},
        '{KIND_POLL, 8'h00, CHK_NOT_FOUND},     // stop marker wrong
        '{KIND_PUSH, 8'hFF, CHK_PREDICTED},
        '{KIND_PUSH, 8'h01, CHK_PREDICTED},
        '{KIND_PUSH, 8'h80, CHK_PREDICTED},
        '{KIND_PUSH, 8'h00, CHK_PREDICTED},
        '{KIND_PUSH, 8'h8D, CHK_PREDICTED},     // CRC of 80 is 8C
        '{KIND_POLL, 8'hFF, CHK_NOT_FOUND}      // CRC wrong
    };

    crc8_packet_deframer uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),      // [7:0] rx_byte
        .i_s_tuser  (s_tuser),      // [0] kind
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),    // [5:0] length, [11:6] index, [19:12] byte
        .o_m_tuser  (o_m_tuser),    // [0] found, [1] overflowed
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] ring_at(input int unsigned offset);
        return ring[PTR_W'((ring_head + offset) % STORE_DEPTH)];
    endfunction

    function automatic void ring_drop(input int unsigned n);
        int unsigned k;
        k = (n > ring_count) ? ring_count : n;
        ring_head  = (ring_head + k) % STORE_DEPTH;
        ring_count = ring_count - k;
    endfunction

    // Reflected CRC-8, bits taken least significant first.
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            c = {1'b0, c[7:1]} ^ ((c[0] ^ b[k]) ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Applies one item to the model and leaves its results in poll_results.
    function automatic void deframe_item(input logic kind, input logic [7:0] b);
        t_result     r;
        int unsigned len;
        logic [7:0]  crc;
        poll_results.delete();
        if (kind == KIND_PUSH) begin
            if (ring_count >= STORE_DEPTH) begin
                overflow_seen = 1'b1;
            end else begin
                ring[PTR_W'((ring_head + ring_count) % STORE_DEPTH)] = b;
                ring_count++;
            end
            return;
        end
        r = '0;
        r.last = 1'b1;
        r.overflowed = overflow_seen;
        overflow_seen = 1'b0;
        while (ring_count > 0 && ring_at(0) != start_byte) begin
            ring_drop(1);
        end
        if (ring_count <= 1) begin
            poll_results.push_back(r);
            return;
        end
        len = 32'(ring_at(1));
        if (len > FIT_LIMIT) begin
            ring_drop(1);
            poll_results.push_back(r);
            return;
        end
        if (ring_count < 4 + len) begin
            poll_results.push_back(r);
            return;
        end
        if (ring_at(2 + len) != stop_byte) begin
            ring_drop(1);
            poll_results.push_back(r);
            return;
        end
        crc = CRC_INIT;
        for (int i = 0; i < len; i++) begin
            crc = crc_fold(crc, ring_at(2 + i));
        end
        if (crc != ring_at(3 + len)) begin
            ring_drop(1);
            poll_results.push_back(r);
            return;
        end
        r.found = 1'b1;
        if (len == 0) begin
            poll_results.push_back(r);
        end
        for (int i = 0; i < len; i++) begin
            r.payload_length = 6'(len);
            r.byte_index     = 6'(i);
            r.data_byte      = ring_at(2 + i);
            r.last           = (i + 1 == len);
            poll_results.push_back(r);
        end
        ring_drop(4 + len);
    endfunction

    // Offers one item, waits for it to be taken, then maybe leaves a gap.
    task automatic send_item(input logic kind, input logic [7:0] b, input t_check chk);
        t_result     typed;
        int unsigned gap;
        int unsigned r;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= kind;
        do @(posedge clk); while (o_s_tready !== 1'b1);
        items_sent++;
        deframe_item(kind, b);
        if (chk == CHK_PREDICTED) begin
            foreach (poll_results[i]) results_due.push_back(poll_results[i]);
        end else begin
            typed = '0;
            typed.found = (chk == CHK_EMPTY_FRAME);
            typed.last = 1'b1;
            results_due.push_back(typed);
        end
        r = $urandom_range(0, 99);
        if (r < 70) gap = 0;
        else if (r < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic apb_write(input logic idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_START) start_byte = value;
        else stop_byte = value;
        @(posedge clk);
    endtask

    // Every result in, then time for trailing pushes to land in the store.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Polls until the store is empty, padding a stuck partial frame so it resolves.
    task automatic drain_store();
        int unsigned held;
        while (ring_count != 0) begin
            held = ring_count;
            send_item(KIND_POLL, 8'($urandom_range(0, 255)), CHK_PREDICTED);
            if (ring_count == held) begin
                send_item(KIND_PUSH, 8'($urandom_range(0, 255)), CHK_PREDICTED);
            end
        end
    endtask

    task automatic send_frame(input int unsigned len, input t_frame_flaw flaw,
                              input int unsigned noise, input int unsigned extra);
        logic [7:0]  frame_bytes [$];
        logic [7:0]  crc;
        logic [7:0]  b;
        int unsigned cut;
        crc = CRC_INIT;
        frame_bytes.push_back(start_byte);
        if (flaw == FLAW_LENGTH) frame_bytes.push_back(8'($urandom_range(FIT_LIMIT + 1, 255)));
        else frame_bytes.push_back(8'(len));
        repeat (len) begin
            b = 8'($urandom_range(0, 255));
            crc = crc_fold(crc, b);
            frame_bytes.push_back(b);
        end
        if (flaw == FLAW_STOP) frame_bytes.push_back(stop_byte ^ 8'($urandom_range(1, 255)));
        else frame_bytes.push_back(stop_byte);
        if (flaw == FLAW_CRC) frame_bytes.push_back(crc ^ 8'($urandom_range(1, 255)));
        else frame_bytes.push_back(crc);
        repeat (extra) frame_bytes.push_back(8'($urandom_range(0, 255)));
        // A short frame gets polled once before its tail has arrived.
        cut = (flaw == FLAW_SHORT) ? $urandom_range(1, len + 3) : 0;
        repeat (noise) send_item(KIND_PUSH, 8'($urandom_range(0, 255)), CHK_PREDICTED);
        foreach (frame_bytes[i]) begin
            if (cut != 0 && i == cut) begin
                send_item(KIND_POLL, 8'($urandom_range(0, 255)), CHK_PREDICTED);
            end
            send_item(KIND_PUSH, frame_bytes[i], CHK_PREDICTED);
        end
        send_item(KIND_POLL, 8'($urandom_range(0, 255)), CHK_PREDICTED);
        if ($urandom_range(0, 4) == 0) begin
            send_item(KIND_POLL, 8'($urandom_range(0, 255)), CHK_PREDICTED);
        end
    endtask

    task automatic random_frame();
        int unsigned noise;
        int unsigned room;
        int unsigned cap;
        int unsigned len;
        int unsigned r;
        t_frame_flaw flaw;
        noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (STORE_DEPTH - ring_count < noise + 8) drain_store();
        room = STORE_DEPTH - ring_count - noise - 4;
        cap = (room > FIT_LIMIT) ? FIT_LIMIT : room;
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(0, (cap < 6) ? cap : 6);
        else if (r < 95) len = $urandom_range(0, (cap < 20) ? cap : 20);
        else len = $urandom_range(0, cap);
        r = $urandom_range(0, 99);
        if (r < 64) flaw = FLAW_NONE;
        else if (r < 73) flaw = FLAW_STOP;
        else if (r < 82) flaw = FLAW_CRC;
        else if (r < 91) flaw = FLAW_LENGTH;
        else flaw = FLAW_SHORT;
        send_frame(len, flaw, noise, 0);
    endtask

    task automatic run_phase(input logic [7:0] start_value, input logic [7:0] stop_value,
                             input t_phase_extra extra);
        int unsigned target;
        wait_idle();
        apb_write(REG_START, start_value);
        apb_write(REG_STOP, stop_value);
        target = items_sent + PHASE_ITEMS;
        if (extra == EXTRA_BACKPRESSURE) hold_req = 1'b1;
        if (extra == EXTRA_OVERFLOW) begin
            // Largest frame fills the store exactly; the trailing bytes overflow it.
            drain_store();
            send_frame(FIT_LIMIT, FLAW_NONE, 0, 3);
        end
        while (items_sent < target) random_frame();
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && o_m_tvalid === 1'b1 && m_tready) begin
            seen.found          = o_m_tuser[0];
            seen.overflowed     = o_m_tuser[1];
            seen.payload_length = o_m_tdata[5:0];
            seen.byte_index     = o_m_tdata[11:6];
            seen.data_byte      = o_m_tdata[19:12];
            seen.last           = o_m_tlast;
            if (results_due.size() == 0) begin
                fail_count++;
                $display("%0t: result with none expected, got %0h", $time, seen);
            end else begin
                due = results_due.pop_front();
                check_field("found", 8'(due.found), 8'(seen.found));
                check_field("payload_length", 8'(due.payload_length),
                            8'(seen.payload_length));
                check_field("byte_index", 8'(due.byte_index), 8'(seen.byte_index));
                check_field("data_byte", due.data_byte, seen.data_byte);
                check_field("last", 8'(due.last), 8'(seen.last));
                check_field("overflowed", 8'(due.overflowed), 8'(seen.overflowed));
            end
        end
    end

    // Output side: random ready pattern, plus one long hold-off on request.
    initial begin
        int unsigned stretch;
        int unsigned r;
        stretch = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                stretch = HOLD_CYCLES;
            end else if (stretch != 0) begin
                stretch--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_tready <= 1'b1;
                    stretch = $urandom_range(1, 8);
                end else if (r < 65) begin
                    m_tready <= 1'b1;
                    stretch = $urandom_range(20, 60);
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                    stretch = $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    stretch = $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && o_s_tready === 1'b1) || (o_m_tvalid === 1'b1 && m_tready) ||
                (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("crc8_packet_deframer regression: fail");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i]) send_item(directed[i].kind, directed[i].data, directed[i].chk);
        run_phase(8'h00, 8'hFF, EXTRA_BACKPRESSURE);
        run_phase(8'h7E, 8'h7E, EXTRA_NONE);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), EXTRA_NONE);
        run_phase(8'hFF, 8'h00, EXTRA_OVERFLOW);
        wait_idle();
        if (fail_count == 0) begin
            $display("crc8_packet_deframer regression: pass");
        end else begin
            $display("crc8_packet_deframer regression: fail");
        end
        $finish;
    end

endmodule
